// ===== design/cspa_pkg.sv =====
// ----------------------------------------------------------------------------
// cspa_pkg
// Shared types and codes of the chunked slot pool allocator.
// ----------------------------------------------------------------------------
package cspa_pkg;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FOREIGN = 2'd1;
  localparam logic [1:0] ST_DOUBLE  = 2'd2;
  localparam logic [1:0] ST_NOCHUNK = 2'd3;

  localparam logic CFG_SLOTS = 1'b0;
  localparam logic CFG_BYTES = 1'b1;

  localparam logic [17:0] OFFSET_MAX = 18'h3FFFF;

  typedef struct packed {
    logic       op;
    logic [2:0] free_chunk;
    logic [5:0] free_slot;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  chunk_number;
    logic [5:0]  slot_number;
    logic [17:0] byte_offset;
    logic        chunk_created;
    logic        chunk_released;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture request
    logic walk;    // pick chunk in order, rescan if needed
    logic commit;  // update state, build response
  } cmd_t;

endpackage

// ===== design/cspa_ctrl.sv =====
// ----------------------------------------------------------------------------
// cspa_ctrl
// Sequencer: load, walk, commit, then hold the response until taken.
// ----------------------------------------------------------------------------
module cspa_ctrl
  import cspa_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output cmd_t cmd_o
);

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_COMMIT, S_OUT} state_e;
  state_e state_q;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign cmd_o.load   = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.walk   = (state_q == S_WALK);
  assign cmd_o.commit = (state_q == S_COMMIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      case (state_q)
        S_IDLE:   if (in_valid_i) state_q <= S_WALK;
        S_WALK:   state_q <= S_COMMIT;
        S_COMMIT: state_q <= S_OUT;
        S_OUT:    if (!out_stall_i) state_q <= S_IDLE;
        default:  state_q <= S_IDLE;
      endcase
    end
  end

  a_out_only_in_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("response while accepting");
  a_walk_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> cmd_o.walk) else $error("walk missing after load");
  a_commit_after_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.walk |=> cmd_o.commit) else $error("commit missing after walk");

endmodule

// ===== design/cspa_dp.sv =====
// ----------------------------------------------------------------------------
// cspa_dp
// Chunk state, order list, slot search and response build.
// ----------------------------------------------------------------------------
module cspa_dp
  import cspa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  input  req_t        req_i,
  input  logic [6:0]  slots_i,
  input  logic [12:0] bytes_i,
  output rsp_t        rsp_o
);

  localparam int NC = 8;

  logic [NC-1:0][63:0] map_q;
  logic [NC-1:0][6:0]  cur_q;
  logic [NC-1:0][6:0]  cnt_q;
  logic [NC-1:0]       live_q;
  logic [NC-1:0][2:0]  ord_q;
  logic [3:0]          lcnt_q;
  req_t                req_q;
  rsp_t                rsp_q;

  // walk results
  logic       found_q;
  logic [2:0] sel_q;
  logic [6:0] scur_q;  // cursor of selected chunk after rescan

  logic [6:0] n;
  assign n = (slots_i == 7'd0) ? 7'd1 : ((slots_i > 7'd64) ? 7'd64 : slots_i);

  logic [63:0] inrange;
  always_comb begin
    for (int b = 0; b < 64; b++) inrange[b] = (7'(b) < n);
  end

  // first free slot within the mask, 64 if none
  function automatic logic [6:0] first_free(logic [63:0] m, logic [63:0] msk);
    logic [63:0] f;
    logic [6:0]  r;
    f = ~m & msk;
    r = 7'd64;
    for (int b = 63; b >= 0; b--) if (f[b]) r = 7'(b);
    return r;
  endfunction

  // walk: per order position, effective cursor, then first qualifying;
  // every chunk visited up to the chosen one keeps its rescanned cursor
  logic               w_found;
  logic [2:0]         w_sel;
  logic [6:0]         w_cur;
  logic [NC-1:0]      w_upd;
  logic [NC-1:0][6:0] w_val;
  always_comb begin
    logic [2:0] k;
    logic [6:0] c;
    logic       rescan;
    w_found = 1'b0;
    w_sel   = '0;
    w_cur   = '0;
    w_upd   = '0;
    w_val   = '0;
    for (int i = 0; i < NC; i++) begin
      k = ord_q[i];
      c = cur_q[k];
      rescan = (c >= n && cnt_q[k] != 7'd0);
      if (rescan) begin
        c = first_free(map_q[k], inrange);
        if (c > n) c = n;
      end
      if (!w_found && 4'(i) < lcnt_q) begin
        if (rescan) begin
          w_upd[k] = 1'b1;
          w_val[k] = c;
        end
        if (c < n) begin
          w_found = 1'b1;
          w_sel   = k;
          w_cur   = c;
        end
      end
    end
  end

  // next cursor after taking the selected slot, clipped to the slot count
  logic [6:0] nxt_cur;
  always_comb begin
    nxt_cur = first_free(map_q[sel_q] | (64'd1 << scur_q[5:0]),
                         inrange & ~((64'd2 << scur_q[5:0]) - 64'd1));
    if (nxt_cur > n) nxt_cur = n;
  end

  logic [2:0] newc;
  logic       have_new;
  always_comb begin
    newc = '0;
    have_new = 1'b0;
    for (int c = NC - 1; c >= 0; c--)
      if (!live_q[c]) begin newc = 3'(c); have_new = 1'b1; end
  end

  // offset multiply on the slot chosen at walk time, slot 0 of a new chunk, or the freed slot
  logic [5:0]  off_slot;
  logic [18:0] prod;
  logic [17:0] off;
  assign off_slot = (req_q.op == OP_FREE) ? req_q.free_slot
                  : (found_q ? scur_q[5:0] : 6'd0);
  assign prod = 19'(off_slot * bytes_i);
  assign off  = (prod > 19'(OFFSET_MAX)) ? OFFSET_MAX : prod[17:0];

  // order position of a chunk
  logic [2:0] fpos;
  always_comb begin
    fpos = '0;
    for (int i = NC - 1; i >= 0; i--) if (ord_q[i] == req_q.free_chunk) fpos = 3'(i);
  end

  assign rsp_o = rsp_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= req_i;
    if (cmd_i.walk) begin
      found_q <= w_found;
      sel_q   <= w_sel;
      scur_q  <= w_cur;
    end
    if (cmd_i.commit) begin
      rsp_q <= '0;
      if (req_q.op == OP_ALLOC) begin
        if (!found_q && (lcnt_q >= 4'(NC) || !have_new)) begin
          rsp_q.status <= ST_NOCHUNK;
        end else begin
          rsp_q.status        <= ST_OK;
          rsp_q.chunk_number  <= found_q ? sel_q : newc;
          rsp_q.slot_number   <= off_slot;
          rsp_q.byte_offset   <= off;
          rsp_q.chunk_created <= !found_q;
        end
      end else if (!live_q[req_q.free_chunk] || {1'b0, req_q.free_slot} >= n) begin
        rsp_q.status <= ST_FOREIGN;
      end else begin
        rsp_q.chunk_number <= req_q.free_chunk;
        rsp_q.slot_number  <= req_q.free_slot;
        if (!map_q[req_q.free_chunk][req_q.free_slot]) begin
          rsp_q.status <= ST_DOUBLE;
        end else begin
          rsp_q.status         <= ST_OK;
          rsp_q.byte_offset    <= off;
          rsp_q.chunk_released <= ((cnt_q[req_q.free_chunk] == 7'd127 ? 7'd127
                                   : cnt_q[req_q.free_chunk] + 7'd1) >= n);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q  <= '0;
      cur_q  <= '0;
      cnt_q  <= '0;
      live_q <= '0;
      lcnt_q <= '0;
    end else if (cmd_i.commit) begin
      if (req_q.op == OP_ALLOC) begin
        if (found_q) begin
          map_q[sel_q][scur_q[5:0]] <= 1'b1;
          if (cnt_q[sel_q] != 7'd0) cnt_q[sel_q] <= cnt_q[sel_q] - 7'd1;
          cur_q[sel_q] <= nxt_cur;
        end else if (lcnt_q < 4'(NC) && have_new) begin
          live_q[newc]   <= 1'b1;
          map_q[newc]    <= 64'd1;
          cnt_q[newc]    <= n - 7'd1;
          cur_q[newc]    <= (n > 7'd1) ? 7'd1 : n;
          ord_q[lcnt_q[2:0]] <= newc;
          lcnt_q         <= lcnt_q + 4'd1;
        end
      end else if (live_q[req_q.free_chunk] && {1'b0, req_q.free_slot} < n
                   && map_q[req_q.free_chunk][req_q.free_slot]) begin
        map_q[req_q.free_chunk][req_q.free_slot] <= 1'b0;
        if (cnt_q[req_q.free_chunk] != 7'd127)
          cnt_q[req_q.free_chunk] <= cnt_q[req_q.free_chunk] + 7'd1;
        if ((cnt_q[req_q.free_chunk] == 7'd127 ? 7'd127
             : cnt_q[req_q.free_chunk] + 7'd1) >= n) begin
          live_q[req_q.free_chunk] <= 1'b0;
          for (int i = 0; i < NC - 1; i++)
            if (3'(i) >= fpos) ord_q[i] <= ord_q[i + 1];
          lcnt_q <= lcnt_q - 4'd1;
        end
      end
    end else if (cmd_i.walk && req_q.op == OP_ALLOC) begin
      for (int j = 0; j < NC; j++)
        if (w_upd[j]) cur_q[j] <= w_val[j];
    end
  end

  a_lcnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lcnt_q <= 4'(NC)) else $error("live count overflow");
  a_lcnt_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    4'($countones(live_q)) == lcnt_q) else $error("live count mismatch");
  a_sel_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && found_q |-> live_q[sel_q]) else $error("dead chunk chosen");

endmodule

// ===== design/chunked_slot_pool_allocator.sv =====
// ----------------------------------------------------------------------------
// chunked_slot_pool_allocator
// Slab pool allocator over eight chunks of up to 64 slots.
// ----------------------------------------------------------------------------
// Flow: an accepted request passes the walk and commit states, then the response is held valid.
// A new request is stalled until the response is taken (walk, commit, response states).
// The order walk and bitmap search run combinationally in the walk state by priority encoders.
// Reset: all chunks free, slots_in_use 64, object_bytes 8.
module chunked_slot_pool_allocator
  import cspa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  req_t        in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output rsp_t        out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [12:0] cfg_data_i
);

  logic [6:0]  slots_q;
  logic [12:0] bytes_q;
  cmd_t        cmd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q <= 7'd64;
      bytes_q <= 13'd8;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SLOTS: slots_q <= cfg_data_i[6:0];
        CFG_BYTES: bytes_q <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  cspa_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .cmd_o(cmd)
  );

  cspa_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .req_i(in_data_i),
    .slots_i(slots_q), .bytes_i(bytes_q), .rsp_o(out_data_o)
  );

endmodule

// ===== dv/tb_chunked_slot_pool_allocator.sv =====
// ----------------------------------------------------------------------------
// tb_chunked_slot_pool_allocator
// Self-checking bench for the slab pool allocator. A behavioral pool model
// predicts every response; directed requests cover the corner cases, then
// random alloc/free traffic runs under several configurations and stall mixes.
// ----------------------------------------------------------------------------
module tb_chunked_slot_pool_allocator;
  import cspa_pkg::*;

  localparam int NCHUNK     = 8;
  localparam int NSLOT      = 64;
  localparam int WDOG_LIMIT = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  req_t        in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  rsp_t        out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = 1'b0;
  logic [12:0] cfg_data_i = '0;

  chunked_slot_pool_allocator uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // pool model
  logic [63:0] used_map [NCHUNK];
  logic [6:0]  cursor   [NCHUNK];
  logic [6:0]  free_cnt [NCHUNK];
  logic        live     [NCHUNK];
  logic [2:0]  order    [NCHUNK];
  int          nlive;
  logic [6:0]  cfg_slots = 7'd64;
  logic [12:0] cfg_bytes = 13'd8;

  rsp_t rsp_pending [$];
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   idle_cycles;
  bit   failed = 1'b0;

  function automatic int slot_limit();
    if (cfg_slots == 0) return 1;
    if (cfg_slots > NSLOT) return NSLOT;
    return cfg_slots;
  endfunction

  function automatic logic [6:0] next_free(int c, int start, int n);
    int s;
    s = start;
    while (s < n && used_map[c][s]) s++;
    return 7'(s);
  endfunction

  function automatic logic [17:0] offset_for(int s);
    longint v;
    v = longint'(s) * longint'(cfg_bytes);
    return (v > OFFSET_MAX) ? OFFSET_MAX : 18'(v);
  endfunction

  function automatic rsp_t predict_pool(req_t rq);
    rsp_t r;
    int n, c, s, pos;
    bit found;
    r = '0;
    n = slot_limit();
    if (rq.op == OP_ALLOC) begin
      found = 1'b0;
      c = 0;
      for (int i = 0; i < nlive; i++) begin
        int k;
        k = order[i];
        if (cursor[k] >= n && free_cnt[k] > 0) cursor[k] = next_free(k, 0, n);
        if (cursor[k] < n) begin
          c = k;
          found = 1'b1;
          break;
        end
      end
      if (!found) begin
        c = 0;
        while (c < NCHUNK && live[c]) c++;
        if (nlive >= NCHUNK || c >= NCHUNK) begin
          r.status = ST_NOCHUNK;
          return r;
        end
        live[c] = 1'b1;
        used_map[c] = '0;
        cursor[c] = '0;
        free_cnt[c] = 7'(n);
        order[nlive] = 3'(c);
        nlive++;
        r.chunk_created = 1'b1;
      end
      s = cursor[c];
      used_map[c][s] = 1'b1;
      if (free_cnt[c] > 0) free_cnt[c]--;
      cursor[c] = next_free(c, s + 1, n);
      r.status = ST_OK;
      r.chunk_number = 3'(c);
      r.slot_number = 6'(s);
      r.byte_offset = offset_for(s);
      return r;
    end
    c = rq.free_chunk;
    s = rq.free_slot;
    if (!live[c] || s >= n) begin
      r.status = ST_FOREIGN;
      return r;
    end
    r.chunk_number = 3'(c);
    r.slot_number = 6'(s);
    if (!used_map[c][s]) begin
      r.status = ST_DOUBLE;
      return r;
    end
    used_map[c][s] = 1'b0;
    if (free_cnt[c] < 127) free_cnt[c]++;
    r.byte_offset = offset_for(s);
    if (free_cnt[c] >= n) begin
      pos = nlive;
      for (int i = 0; i < nlive; i++)
        if (order[i] == c) begin
          pos = i;
          break;
        end
      if (pos < nlive) begin
        for (int i = pos; i + 1 < nlive; i++) order[i] = order[i + 1];
        nlive--;
      end
      live[c] = 1'b0;
      r.chunk_released = 1'b1;
    end
    return r;
  endfunction

  task automatic send_request(logic op, logic [2:0] ch, logic [5:0] sl);
    req_t rq;
    rq.op = op;
    rq.free_chunk = ch;
    rq.free_slot = sl;
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    // move off the edge that dropped the previous request
    @(negedge clk_i);
    in_data_i <= rq;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    rsp_pending.push_back(predict_pool(rq));
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic drain_responses();
    while (rsp_pending.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [12:0] val);
    drain_responses();
    cfg_index_i <= idx;
    cfg_data_i <= val;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CFG_SLOTS) cfg_slots = val[6:0];
    else cfg_bytes = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // random free of a slot that is (mostly) allocated
  task automatic free_any();
    int c, s, n;
    n = slot_limit();
    c = $urandom_range(NCHUNK - 1);
    s = $urandom_range(n - 1);
    for (int t = 0; t < 16 && !(live[c] && used_map[c][s]); t++) begin
      c = $urandom_range(NCHUNK - 1);
      s = $urandom_range(n - 1);
    end
    send_request(OP_FREE, 3'(c), 6'(s));
  endtask

  always @(posedge clk_i) begin
    rsp_t exp_rsp;
    if (out_valid_o && !out_stall_i) begin
      if (rsp_pending.size() == 0) begin
        $display("%0t unexpected response %h", $time, out_data_o);
        failed = 1'b1;
      end else begin
        exp_rsp = rsp_pending.pop_front();
        if (out_data_o !== exp_rsp) begin
          $display("%0t mismatch: expected st=%0d ch=%0d sl=%0d off=%0d cr=%0b rl=%0b",
                   $time, exp_rsp.status, exp_rsp.chunk_number, exp_rsp.slot_number,
                   exp_rsp.byte_offset, exp_rsp.chunk_created, exp_rsp.chunk_released);
          $display("%0t          actual   st=%0d ch=%0d sl=%0d off=%0d cr=%0b rl=%0b",
                   $time, out_data_o.status, out_data_o.chunk_number,
                   out_data_o.slot_number, out_data_o.byte_offset,
                   out_data_o.chunk_created, out_data_o.chunk_released);
          failed = 1'b1;
        end
      end
    end
  end

  always @(negedge clk_i)
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic test_directed();
    send_idle_pct = 8;  recv_idle_pct = 64;
    send_request(OP_FREE, 3'd0, 6'd0);    // foreign: nothing live
    send_request(OP_ALLOC, 3'd7, 6'd63);
    send_request(OP_ALLOC, 3'd0, 6'd0);
    send_request(OP_FREE, 3'd0, 6'd1);
    send_request(OP_FREE, 3'd0, 6'd1);    // double free
    send_request(OP_FREE, 3'd0, 6'd63);   // double free, top slot
    send_request(OP_FREE, 3'd7, 6'd5);    // foreign: chunk not live
    send_request(OP_FREE, 3'd0, 6'd0);    // empties and drops chunk
    write_reg(CFG_SLOTS, 13'd0);          // used as one slot
    write_reg(CFG_BYTES, 13'd0);
    for (int i = 0; i < 9; i++) send_request(OP_ALLOC, 3'd0, 6'd0); // last: out of chunks
    send_request(OP_FREE, 3'd3, 6'd1);    // foreign: slot above count
    send_request(OP_FREE, 3'd3, 6'd0);
    send_request(OP_ALLOC, 3'd0, 6'd0);
    write_reg(CFG_SLOTS, 13'd127);        // clipped to 64
    write_reg(CFG_BYTES, 13'h1FFF);       // largest object_bytes value
    send_request(OP_ALLOC, 3'd0, 6'd0);
    for (int c = 0; c < NCHUNK; c++) send_request(OP_FREE, 3'(c), 6'd0);
  endtask

  task automatic test_random(int nitems, int alloc_pct);
    for (int i = 0; i < nitems; i++) begin
      if ($urandom_range(19) == 0)
        send_request(1'($urandom), 3'($urandom), 6'($urandom));
      else if ($urandom_range(99) < alloc_pct)
        send_request(OP_ALLOC, 3'($urandom), 6'($urandom));
      else
        free_any();
    end
  endtask

  task automatic test_configs();
    send_idle_pct = 8;  recv_idle_pct = 64;
    write_reg(CFG_SLOTS, 13'd4);  write_reg(CFG_BYTES, 13'd24);
    test_random(300, 60);
    write_reg(CFG_SLOTS, 13'd1);  write_reg(CFG_BYTES, 13'd4096);
    test_random(200, 55);
    send_idle_pct = 64; recv_idle_pct = 8;
    write_reg(CFG_SLOTS, 13'd64); write_reg(CFG_BYTES, 13'd8);
    test_random(500, 70);
    write_reg(CFG_SLOTS, 13'd3);  // shrink with chunks live
    test_random(300, 50);
    send_idle_pct = 0;  recv_idle_pct = 0;
    write_reg(CFG_SLOTS, 13'd7);  write_reg(CFG_BYTES, 13'd4095);
    test_random(400, 55);
    write_reg(CFG_SLOTS, 13'd64); // grow with chunks live
    test_random(300, 50);
  endtask

  initial begin
    for (int c = 0; c < NCHUNK; c++) begin
      used_map[c] = '0; cursor[c] = '0; free_cnt[c] = '0; live[c] = 1'b0;
      order[c] = '0;
    end
    nlive = 0;
    idle_cycles = 0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_configs();
    drain_responses();
    if (!failed && rsp_pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
